// ----- hw/rtl/lcrl_pkg.sv -----
// Shared types and constants of the rate limited lead compensator.
package lcrl_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned MulDigitW = 8;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_GAIN = 3'd0,
    CFG_POLE = 3'd1,
    CFG_ZERO = 3'd2,
    CFG_STEP = 3'd3,
    CFG_CMAX = 3'd4,
    CFG_CMIN = 3'd5,
    CFG_RATE = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } unit_stat_t;

  localparam logic [63:0] GainRst = 64'd26214;
  localparam logic [63:0] PoleRst = 64'd65536;
  localparam logic [63:0] ZeroRst = 64'd1179648;
  localparam logic [63:0] StepRst = 64'd6554;
  localparam logic [63:0] CmaxRst = 64'd655360;
  localparam logic [63:0] CminRst = 64'hFFFF_FFFF_FFF6_0000;
  localparam logic [63:0] RateRst = 64'd6553600;

endpackage

// ----- hw/rtl/lcrl_cfg.sv -----
// Configuration register file of the rate limited lead compensator.
module lcrl_cfg #(
  parameter int unsigned DataW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [lcrl_pkg::CfgIndexW-1:0]  index_i,
  input  logic [DataW-1:0]                data_i,
  output logic [DataW-1:0]                gain_o,
  output logic [DataW-2:0]                pole_o,
  output logic [DataW-2:0]                zero_o,
  output logic [DataW-2:0]                tstep_o,
  output logic [DataW-1:0]                cmax_o,
  output logic [DataW-1:0]                cmin_o,
  output logic [DataW-2:0]                rate_o
);

  localparam logic [DataW-1:0] GainInit = lcrl_pkg::GainRst[DataW-1:0];
  localparam logic [DataW-2:0] PoleInit = lcrl_pkg::PoleRst[DataW-2:0];
  localparam logic [DataW-2:0] ZeroInit = lcrl_pkg::ZeroRst[DataW-2:0];
  localparam logic [DataW-2:0] StepInit = lcrl_pkg::StepRst[DataW-2:0];
  localparam logic [DataW-1:0] CmaxInit = lcrl_pkg::CmaxRst[DataW-1:0];
  localparam logic [DataW-1:0] CminInit = lcrl_pkg::CminRst[DataW-1:0];
  localparam logic [DataW-2:0] RateInit = lcrl_pkg::RateRst[DataW-2:0];

  logic [DataW-1:0] gain_q, cmax_q, cmin_q;
  logic [DataW-2:0] pole_q, zero_q, tstep_q, rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainInit;
      pole_q  <= PoleInit;
      zero_q  <= ZeroInit;
      tstep_q <= StepInit;
      cmax_q  <= CmaxInit;
      cmin_q  <= CminInit;
      rate_q  <= RateInit;
    end else if (we_i) begin
      case (lcrl_pkg::cfg_reg_e'(index_i))
        lcrl_pkg::CFG_GAIN: gain_q  <= data_i;
        lcrl_pkg::CFG_POLE: pole_q  <= data_i[DataW-2:0];
        lcrl_pkg::CFG_ZERO: zero_q  <= data_i[DataW-2:0];
        lcrl_pkg::CFG_STEP: tstep_q <= data_i[DataW-2:0];
        lcrl_pkg::CFG_CMAX: cmax_q  <= data_i;
        lcrl_pkg::CFG_CMIN: cmin_q  <= data_i;
        lcrl_pkg::CFG_RATE: rate_q  <= data_i[DataW-2:0];
        default: ;
      endcase
    end
  end

  assign gain_o  = gain_q;
  assign pole_o  = pole_q;
  assign zero_o  = zero_q;
  assign tstep_o = tstep_q;
  assign cmax_o  = cmax_q;
  assign cmin_o  = cmin_q;
  assign rate_o  = rate_q;

endmodule

// ----- hw/rtl/lcrl_unit.sv -----
// Shared iterative unit: digit-serial unsigned multiply and restoring divide.
module lcrl_unit #(
  parameter int unsigned DataW  = 32,
  parameter int unsigned McandW = 32,
  localparam int unsigned ProdW = McandW + DataW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcrl_pkg::unit_ctrl_t   ctrl_i,
  input  logic [McandW-1:0]      mcand_i,
  input  logic [DataW-1:0]       mplier_i,
  input  logic [ProdW-1:0]       dividend_i,
  input  logic [DataW-1:0]       divisor_i,
  output lcrl_pkg::unit_stat_t   stat_o,
  output logic [ProdW-1:0]       product_o,
  output logic [DataW-1:0]       quot_o
);

  localparam int unsigned DigW   = lcrl_pkg::MulDigitW;
  localparam int unsigned NumDig = (DataW + DigW - 1) / DigW;
  localparam int unsigned MrW    = NumDig * DigW;
  localparam int unsigned CntW   = $clog2(DataW + 1);

  logic                  busy_q, done_q, ovf_q;
  lcrl_pkg::unit_op_e    op_q;
  logic [CntW-1:0]       cnt_q;
  logic [ProdW-1:0]      acc_q;
  logic [MrW-1:0]        mr_q;
  logic [McandW-1:0]     mc_q;
  logic [DataW-1:0]      rem_q, q_q, dv_q;

  logic [DigW-1:0]        digit;
  logic [McandW+DigW-1:0] pprod;
  logic [ProdW-1:0]       acc_next;
  logic [DataW+1:0]       trial;
  logic                   start_ovf;

  // The product is built from the most significant digit of the multiplier down.
  assign digit     = mr_q[MrW-1 -: DigW];
  assign pprod     = mc_q * digit;
  assign acc_next  = (acc_q << DigW) + ProdW'(pprod);
  assign trial     = {1'b0, rem_q, q_q[DataW-1]} - {2'b00, dv_q};
  // A quotient of 2^DataW or more is flagged at once and not iterated.
  assign start_ovf = dividend_i[ProdW-1:DataW] >= (ProdW-DataW)'(divisor_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      op_q   <= lcrl_pkg::OP_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        op_q <= ctrl_i.op;
        if (ctrl_i.op == lcrl_pkg::OP_DIV && start_ovf) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          ovf_q  <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          ovf_q  <= 1'b0;
          cnt_q  <= (ctrl_i.op == lcrl_pkg::OP_DIV) ? CntW'(DataW) : CntW'(NumDig);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      if (ctrl_i.op == lcrl_pkg::OP_MUL) begin
        mc_q  <= mcand_i;
        mr_q  <= MrW'(mplier_i);
        acc_q <= '0;
      end else begin
        dv_q  <= divisor_i;
        rem_q <= dividend_i[2*DataW-1:DataW];
        q_q   <= dividend_i[DataW-1:0];
      end
    end else if (busy_q) begin
      if (op_q == lcrl_pkg::OP_MUL) begin
        acc_q <= acc_next;
        mr_q  <= mr_q << DigW;
      end else begin
        q_q   <= {q_q[DataW-2:0], ~trial[DataW+1]};
        rem_q <= trial[DataW+1] ? {rem_q[DataW-2:0], q_q[DataW-1]} : trial[DataW-1:0];
      end
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign product_o   = acc_q;
  assign quot_o      = q_q;

endmodule

// ----- hw/rtl/lead_compensator_rate_limited.sv -----
// Top level of the rate limited lead compensator.
// Each item carries a measurement and a target in signed fixed point and yields one
// drive command: the lead law output, divided by (time_step + pole_time_constant),
// clamped to [command_min, command_max] and limited to a change of rate_max*time_step
// from the previous command. All five products and the division run on one shared
// unit: a multiply runs on its 8-bit digit multiplier, and the divide yields one
// quotient bit per cycle, or flags saturation without iterating when the quotient is
// too large. The input is stalled while an item is in work, so a new item is taken
// only after the last one is through; a finished command waits in the output
// register, and the block only waits for it to drain when the next command is ready.
// Configuration must be written through the plain write port while the block is
// idle; the block itself does not enforce this.
module lead_compensator_rate_limited #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lcrl_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [DATA_WIDTH-1:0]           cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [DATA_WIDTH-1:0]           measured_value_i,
  input  logic [DATA_WIDTH-1:0]           target_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [DATA_WIDTH-1:0]           drive_command_o
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned SW  = 2 * W + 1;
  localparam int unsigned SVW = (SW - F < 64) ? SW - F : 64;
  localparam int unsigned MCW = (SVW > W) ? SVW : W;
  localparam int unsigned PW  = MCW + W;

  localparam logic [W-1:0]  SMax    = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  SMin    = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW:0]   Half    = (PW+1)'(1) << (F - 1);
  localparam logic [PW-1:0] StepCap = {{(PW-W-1){1'b0}}, 1'b1, {W{1'b0}}};

  typedef enum logic [13:0] {
    S_IDLE   = 14'h0001,
    S_DERR   = 14'h0002,
    S_M1     = 14'h0004,
    S_M2     = 14'h0008,
    S_RND    = 14'h0010,
    S_M3I    = 14'h0020,
    S_M3     = 14'h0040,
    S_M4     = 14'h0080,
    S_NABS   = 14'h0100,
    S_DIVI   = 14'h0200,
    S_DIV    = 14'h0400,
    S_M5     = 14'h0800,
    S_LIM1   = 14'h1000,
    S_LIMOUT = 14'h2000
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0]   gain, cmax, cmin;
  logic [W-2:0]   pole, zero, tstep, rate;

  lcrl_pkg::unit_ctrl_t unit_ctrl;
  lcrl_pkg::unit_stat_t unit_stat;
  logic [MCW-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [PW-1:0]  unit_prod;
  logic [W-1:0]   unit_quot;

  logic [W-1:0]   err_q, sv_dummy_unused;
  logic [W:0]     derr_q;
  logic [PW:0]    acc_q;
  logic [SVW-1:0] sv_q;
  logic [PW-1:0]  nmag_q;
  logic           nneg_q, nzero_q;
  logic [W-1:0]   den_q, raw_q, cmd_q;
  logic [W:0]     step_q;
  logic [W+1:0]   upper_q, lower_q;
  logic [W-1:0]   last_err_q, last_raw_q, last_out_q;
  logic           out_valid_q;
  logic [W-1:0]   out_data_q;

  logic           in_acc, out_free;
  logic [W:0]     diff;
  logic [W-1:0]   err_sat, err_mag, gain_mag, raw_mag;
  logic [W:0]     derr_abs;
  logic [SVW-1:0] sv_mag, sv_next;
  logic           prod_neg;
  logic [PW:0]    acc_base, acc_add, rnd, rs, acc_abs;
  logic           sv_fit;
  logic [W-1:0]   raw_next, cmd_clamp, res;
  logic [PW-1:0]  pshift;
  logic [W:0]     step_next;
  logic [W+1:0]   cmd_ext;

  assign sv_dummy_unused = '0;

  lcrl_cfg #(
    .DataW (W)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .gain_o  (gain),
    .pole_o  (pole),
    .zero_o  (zero),
    .tstep_o (tstep),
    .cmax_o  (cmax),
    .cmin_o  (cmin),
    .rate_o  (rate)
  );

  lcrl_unit #(
    .DataW  (W),
    .McandW (MCW)
  ) u_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (unit_ctrl),
    .mcand_i    (mcand),
    .mplier_i   (mplier),
    .dividend_i (nmag_q),
    .divisor_i  (den_q),
    .stat_o     (unit_stat),
    .product_o  (unit_prod),
    .quot_o     (unit_quot)
  );

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign diff    = {target_value_i[W-1], target_value_i} - {measured_value_i[W-1], measured_value_i};
  assign err_sat = (diff[W] != diff[W-1]) ? (diff[W] ? SMin : SMax) : diff[W-1:0];

  assign err_mag  = err_q[W-1] ? (~err_q + W'(1)) : err_q;
  assign derr_abs = derr_q[W] ? (~derr_q + (W+1)'(1)) : derr_q;
  assign gain_mag = gain[W-1] ? (~gain + W'(1)) : gain;
  assign raw_mag  = last_raw_q[W-1] ? (~last_raw_q + W'(1)) : last_raw_q;
  assign sv_mag   = sv_q[SVW-1] ? (~sv_q + SVW'(1)) : sv_q;

  always_comb begin
    case (state_q)
      S_M1:    prod_neg = err_q[W-1];
      S_M2:    prod_neg = derr_q[W];
      S_M3:    prod_neg = gain[W-1] ^ sv_q[SVW-1];
      S_M4:    prod_neg = last_raw_q[W-1];
      default: prod_neg = 1'b0;
    endcase
  end

  // Signed accumulate: the product magnitude is conditionally inverted with a carry in.
  assign acc_base = (state_q == S_M2 || state_q == S_M4) ? acc_q : '0;
  assign acc_add  = acc_base + ({1'b0, unit_prod} ^ {(PW+1){prod_neg}}) + (PW+1)'(prod_neg);

  assign rnd     = acc_q + Half;
  assign rs      = $signed(rnd) >>> F;
  assign sv_fit  = (&rs[PW:SVW-1]) || !(|rs[PW:SVW-1]);
  assign sv_next = sv_fit ? rs[SVW-1:0]
                 : (rs[PW] ? {1'b1, {(SVW-1){1'b0}}} : {1'b0, {(SVW-1){1'b1}}});

  assign acc_abs = acc_q[PW] ? (~acc_q + (PW+1)'(1)) : acc_q;

  always_comb begin
    if (nzero_q) begin
      raw_next = '0;
    end else if (unit_stat.ovf) begin
      raw_next = nneg_q ? SMin : SMax;
    end else if (nneg_q) begin
      raw_next = (unit_quot[W-1] && (|unit_quot[W-2:0])) ? SMin : (~unit_quot + W'(1));
    end else begin
      raw_next = unit_quot[W-1] ? SMax : unit_quot;
    end
  end

  always_comb begin
    if ($signed(raw_q) > $signed(cmax)) begin
      cmd_clamp = cmax;
    end else if ($signed(raw_q) < $signed(cmin)) begin
      cmd_clamp = cmin;
    end else begin
      cmd_clamp = raw_q;
    end
  end

  assign pshift    = unit_prod >> F;
  assign step_next = (pshift > StepCap) ? {1'b1, {W{1'b0}}} : pshift[W:0];

  assign cmd_ext = {{2{cmd_q[W-1]}}, cmd_q};

  always_comb begin
    if ($signed(cmd_ext) > $signed(upper_q)) begin
      res = upper_q[W-1:0];
    end else if ($signed(cmd_ext) < $signed(lower_q)) begin
      res = lower_q[W-1:0];
    end else begin
      res = cmd_q | sv_dummy_unused;
    end
  end

  always_comb begin
    state_d         = state_q;
    unit_ctrl.start = 1'b0;
    unit_ctrl.op    = lcrl_pkg::OP_MUL;
    mcand           = '0;
    mplier          = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DERR;
        end
      end
      S_DERR: begin
        unit_ctrl.start = 1'b1;
        mcand           = MCW'(err_mag);
        mplier          = {1'b0, tstep};
        state_d         = S_M1;
      end
      S_M1: begin
        if (unit_stat.done) begin
          unit_ctrl.start = 1'b1;
          mcand           = MCW'(derr_abs[W-1:0]);
          mplier          = {1'b0, zero};
          state_d         = S_M2;
        end
      end
      S_M2: begin
        if (unit_stat.done) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        state_d = S_M3I;
      end
      S_M3I: begin
        unit_ctrl.start = 1'b1;
        mcand           = MCW'(sv_mag);
        mplier          = gain_mag;
        state_d         = S_M3;
      end
      S_M3: begin
        if (unit_stat.done) begin
          unit_ctrl.start = 1'b1;
          mcand           = MCW'(raw_mag);
          mplier          = {1'b0, pole};
          state_d         = S_M4;
        end
      end
      S_M4: begin
        if (unit_stat.done) begin
          state_d = S_NABS;
        end
      end
      S_NABS: begin
        state_d = S_DIVI;
      end
      S_DIVI: begin
        unit_ctrl.start = 1'b1;
        unit_ctrl.op    = lcrl_pkg::OP_DIV;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (unit_stat.done) begin
          unit_ctrl.start = 1'b1;
          mcand           = MCW'(tstep);
          mplier          = {1'b0, rate};
          state_d         = S_M5;
        end
      end
      S_M5: begin
        if (unit_stat.done) begin
          state_d = S_LIM1;
        end
      end
      S_LIM1: begin
        state_d = S_LIMOUT;
      end
      S_LIMOUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      last_raw_q  <= '0;
      last_out_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_LIMOUT && out_free) begin
        out_valid_q <= 1'b1;
        last_err_q  <= err_q;
        last_raw_q  <= raw_q;
        last_out_q  <= res;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          err_q <= err_sat;
        end
      end
      S_DERR: begin
        derr_q <= {err_q[W-1], err_q} - {last_err_q[W-1], last_err_q};
      end
      S_M1, S_M2, S_M3, S_M4: begin
        if (unit_stat.done) begin
          acc_q <= acc_add;
        end
      end
      S_RND: begin
        sv_q <= sv_next;
      end
      S_NABS: begin
        nmag_q  <= acc_abs[PW-1:0];
        nneg_q  <= acc_q[PW];
        nzero_q <= (acc_q == '0);
        den_q   <= {1'b0, tstep} + {1'b0, pole};
      end
      S_DIV: begin
        if (unit_stat.done) begin
          raw_q <= raw_next;
        end
      end
      S_M5: begin
        cmd_q <= cmd_clamp;
        if (unit_stat.done) begin
          step_q <= step_next;
        end
      end
      S_LIM1: begin
        upper_q <= {{2{last_out_q[W-1]}}, last_out_q} + {1'b0, step_q};
        lower_q <= {{2{last_out_q[W-1]}}, last_out_q} - {1'b0, step_q};
      end
      S_LIMOUT: begin
        if (out_free) begin
          out_data_q <= res;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign drive_command_o = out_data_q;

endmodule

// ----- hw/rtl/lcrl_checker.sv -----
// Port-level checker of the rate limited lead compensator, bound to the top level.
module lcrl_checker #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [DATA_WIDTH-1:0] drive_command_o
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Items taken in and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled while an item is in work");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result offered with no item outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_idle_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> !in_stall_o)
    else $error("input stalled with nothing outstanding");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_command_o))
    else $error("stalled result changed or dropped");

endmodule

bind lead_compensator_rate_limited lcrl_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_lcrl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .drive_command_o (drive_command_o)
);

// ----- tb/lcrl_command_checker.sv -----
// Checker that predicts every drive command of the compensator and compares it.
module lcrl_command_checker
  import lcrl_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIndexW-1:0]  cfg_index_i,
  input  logic [DATA_WIDTH-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [DATA_WIDTH-1:0] measured_value_i,
  input  logic [DATA_WIDTH-1:0] target_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [DATA_WIDTH-1:0] drive_command_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef logic signed [127:0] wide_t;

  localparam longint CmdMax = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint CmdMin = -CmdMax - 1;

  longint gain_q, pole_q, zero_q, step_q, cmax_q, cmin_q, rate_q;
  longint err_q, raw_q, cmd_q;
  logic [DATA_WIDTH-1:0] expected_cmds[$];
  logic [DATA_WIDTH-1:0] want;
  int fail_count = 0;
  int pending = 0;
  int checked = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;

  function automatic logic [DATA_WIDTH-1:0] next_drive_command(
    input logic [DATA_WIDTH-1:0] meas,
    input logic [DATA_WIDTH-1:0] targ
  );
    longint err, derr, den, raw, cmd, limit;
    wide_t sum_w, num_w, mag, quo, step_w;
    err = longint'($signed(targ)) - longint'($signed(meas));
    if (err > CmdMax) err = CmdMax;
    else if (err < CmdMin) err = CmdMin;
    derr = err - err_q;

    sum_w = wide_t'(step_q) * wide_t'(err) + wide_t'(zero_q) * wide_t'(derr);
    sum_w = (sum_w + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    num_w = wide_t'(gain_q) * sum_w + wide_t'(pole_q) * wide_t'(raw_q);
    den = step_q + pole_q;

    if (num_w == 0) begin
      raw = 0;
    end else if (den == 0) begin
      raw = (num_w < 0) ? CmdMin : CmdMax;
    end else begin
      mag = (num_w < 0) ? -num_w : num_w;
      quo = mag / wide_t'(den);
      if (num_w < 0) raw = (quo > wide_t'(-CmdMin)) ? CmdMin : -longint'(quo);
      else raw = (quo > wide_t'(CmdMax)) ? CmdMax : longint'(quo);
    end
    err_q = err;
    raw_q = raw;

    if (raw > cmax_q) cmd = cmax_q;
    else if (raw < cmin_q) cmd = cmin_q;
    else cmd = raw;

    step_w = (wide_t'(rate_q) * wide_t'(step_q)) >>> FRAC_BITS;
    if (step_w > (wide_t'(1) <<< DATA_WIDTH)) limit = longint'(1) <<< DATA_WIDTH;
    else limit = longint'(step_w);
    if (cmd > cmd_q + limit) cmd = cmd_q + limit;
    else if (cmd < cmd_q - limit) cmd = cmd_q - limit;

    cmd_q = cmd;
    return cmd[DATA_WIDTH-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q = longint'(GainRst);
      pole_q = longint'(PoleRst);
      zero_q = longint'(ZeroRst);
      step_q = longint'(StepRst);
      cmax_q = longint'(CmaxRst);
      cmin_q = longint'(CminRst);
      rate_q = longint'(RateRst);
      err_q = 0;
      raw_q = 0;
      cmd_q = 0;
      expected_cmds.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN: gain_q = longint'($signed(cfg_data_i));
          CFG_POLE: pole_q = longint'(cfg_data_i[DATA_WIDTH-2:0]);
          CFG_ZERO: zero_q = longint'(cfg_data_i[DATA_WIDTH-2:0]);
          CFG_STEP: step_q = longint'(cfg_data_i[DATA_WIDTH-2:0]);
          CFG_CMAX: cmax_q = longint'($signed(cfg_data_i));
          CFG_CMIN: cmin_q = longint'($signed(cfg_data_i));
          CFG_RATE: rate_q = longint'(cfg_data_i[DATA_WIDTH-2:0]);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (expected_cmds.size() == 0) begin
          fail_count++;
          $display("%0t: drive_command expected none, actual %0d",
                   $time, $signed(drive_command_i));
        end else begin
          want = expected_cmds.pop_front();
          if (drive_command_i !== want) begin
            fail_count++;
            $display("%0t: drive_command expected %0d, actual %0d",
                     $time, $signed(want), $signed(drive_command_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_cmds.push_back(next_drive_command(measured_value_i, target_value_i));
      end
      pending = expected_cmds.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the compensator testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
  import lcrl_pkg::*;

  localparam int unsigned DataW       = 32;
  localparam int unsigned FracW       = 16;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned CycleLimit  = 600000;
  localparam int          NumRegs     = int'(CFG_RATE) + 1;

  localparam logic [CfgIndexW-1:0] CfgSpareIndex = 3'd7;
  localparam logic [DataW-1:0]     WordMax       = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0]     WordMin       = 32'h8000_0000;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [DataW-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DataW-1:0]     measured = '0;
  logic [DataW-1:0]     target = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DataW-1:0]     drive_command;

  int fail_count, pending, checked;
  int cycle_count = 0;
  int hold_reqs = 0;
  int items_sent = 0;
  int settings_applied = 0;
  logic [DataW-1:0] setpoint = '0;
  logic [DataW-1:0] cfg_vals [NumRegs];

  always #2 clk = ~clk;

  lead_compensator_rate_limited #(
    .DATA_WIDTH(DataW),
    .FRAC_BITS (FracW)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .measured_value_i(measured),
    .target_value_i  (target),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .drive_command_o (drive_command)
  );

  lcrl_command_checker #(
    .DATA_WIDTH(DataW),
    .FRAC_BITS (FracW)
  ) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .measured_value_i(measured),
    .target_value_i  (target),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .drive_command_i (drive_command),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  function automatic logic [DataW-1:0] fx(input int whole);
    return DataW'(whole <<< FracW);
  endfunction

  function automatic logic [DataW-1:0] corner_value();
    case ($urandom_range(0, 5))
      0: return WordMax;
      1: return WordMin;
      2: return '0;
      3: return '1;
      4: return DataW'(1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataW-1:0] with_spare_msb(input logic [DataW-1:0] v);
    return {$urandom_range(0, 1) == 1, v[DataW-2:0]};
  endfunction

  function automatic void set_defaults();
    cfg_vals[CFG_GAIN] = GainRst[DataW-1:0];
    cfg_vals[CFG_POLE] = PoleRst[DataW-1:0];
    cfg_vals[CFG_ZERO] = ZeroRst[DataW-1:0];
    cfg_vals[CFG_STEP] = StepRst[DataW-1:0];
    cfg_vals[CFG_CMAX] = CmaxRst[DataW-1:0];
    cfg_vals[CFG_CMIN] = CminRst[DataW-1:0];
    cfg_vals[CFG_RATE] = RateRst[DataW-1:0];
  endfunction

  function automatic void set_extremes_high();
    cfg_vals[CFG_GAIN] = WordMax;
    cfg_vals[CFG_POLE] = WordMax;
    cfg_vals[CFG_ZERO] = WordMax;
    cfg_vals[CFG_STEP] = WordMax;
    cfg_vals[CFG_CMAX] = WordMax;
    cfg_vals[CFG_CMIN] = WordMin;
    cfg_vals[CFG_RATE] = WordMax;
  endfunction

  task automatic randomize_config();
    logic [DataW-1:0] v;
    v = ($urandom_range(0, 3) == 0) ? $urandom : DataW'($urandom_range(0, 4 << FracW));
    cfg_vals[CFG_GAIN] = $urandom_range(0, 1) ? -v : v;
    v = ($urandom_range(0, 4) == 0) ? $urandom : DataW'($urandom_range(0, 10 << FracW));
    cfg_vals[CFG_POLE] = with_spare_msb(v);
    v = ($urandom_range(0, 4) == 0) ? $urandom : DataW'($urandom_range(0, 40 << FracW));
    cfg_vals[CFG_ZERO] = with_spare_msb(v);
    case ($urandom_range(0, 19))
      0: v = '0;
      1, 2: v = $urandom;
      3, 4, 5, 6: v = $urandom_range(1, 64);
      default: v = $urandom_range(1, 1 << FracW);
    endcase
    cfg_vals[CFG_STEP] = with_spare_msb(v);
    case ($urandom_range(0, 9))
      0: begin
        cfg_vals[CFG_CMAX] = -DataW'($urandom_range(0, 20 << FracW));
        cfg_vals[CFG_CMIN] = DataW'($urandom_range(0, 20 << FracW));
      end
      1, 2: begin
        cfg_vals[CFG_CMAX] = $urandom;
        cfg_vals[CFG_CMIN] = $urandom;
      end
      default: begin
        cfg_vals[CFG_CMAX] = DataW'($urandom_range(0, 50 << FracW));
        cfg_vals[CFG_CMIN] = -DataW'($urandom_range(0, 50 << FracW));
      end
    endcase
    v = ($urandom_range(0, 3) == 0) ? $urandom : DataW'($urandom_range(0, 500 << FracW));
    cfg_vals[CFG_RATE] = with_spare_msb(v);
  endtask

  task automatic apply_config();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIndexW'(i);
      cfg_data  <= cfg_vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_item(input logic [DataW-1:0] meas, input logic [DataW-1:0] targ);
    in_valid <= 1'b1;
    measured <= meas;
    target   <= targ;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic next_sample(output logic [DataW-1:0] meas, output logic [DataW-1:0] targ);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) setpoint = DataW'($urandom_range(0, 60 << FracW)) - fx(30);
      targ = setpoint;
      meas = setpoint + DataW'($urandom_range(0, 4 << FracW)) - fx(2);
    end else if (pick < 85) begin
      targ = $urandom;
      meas = $urandom;
    end else begin
      targ = corner_value();
      meas = corner_value();
    end
  endtask

  task automatic run_items(input int count);
    int burst_left, gap;
    logic [DataW-1:0] meas, targ;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      next_sample(meas, targ);
      send_item(meas, targ);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: gap = 0;
          1, 2: gap = $urandom_range(1, 10);
          default: gap = $urandom_range(11, 70);
        endcase
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin : receiver
    int holds_served, seg_len, pct, period, on_len;
    stall_mode_e mode;
    holds_served = 0;
    forever begin
      if (hold_reqs != holds_served) begin
        holds_served++;
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        seg_len = $urandom_range(8, 60);
        mode    = stall_mode_e'($urandom_range(0, 2));
        pct     = $urandom_range(10, 80);
        period  = $urandom_range(2, 9);
        on_len  = $urandom_range(1, period - 1);
        for (int k = 0; k < seg_len; k++) begin
          @(posedge clk);
          case (mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(1, 100) <= pct);
            default:      out_stall <= ((k % period) < on_len);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    set_defaults();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, including saturation of the error in both directions.
    send_item('0, '0);
    send_item('0, fx(1));
    send_item('0, fx(1));
    send_item(WordMin, WordMax);
    send_item(WordMax, WordMin);
    send_item('1, '0);
    send_item(WordMin, WordMin);
    send_item(WordMax, WordMax);
    wait_idle();

    // Largest registers: saturated command and a capped rate step.
    set_extremes_high();
    apply_config();
    send_item(WordMin, WordMax);
    send_item(WordMax, WordMin);
    send_item('0, '0);
    wait_idle();

    // Zero divisor and zero time step, so the output must hold.
    set_defaults();
    cfg_vals[CFG_GAIN] = fx(1);
    cfg_vals[CFG_POLE] = '0;
    cfg_vals[CFG_STEP] = '0;
    cfg_vals[CFG_RATE] = WordMax;
    apply_config();
    send_item('0, fx(1));
    send_item('0, fx(-1));
    send_item('0, fx(-1));
    wait_idle();

    // Crossed clamp limits.
    set_defaults();
    cfg_vals[CFG_CMAX] = fx(-1);
    cfg_vals[CFG_CMIN] = fx(1);
    cfg_vals[CFG_RATE] = WordMax;
    apply_config();
    send_item('0, fx(50));
    send_item('0, fx(-50));
    send_item('0, '0);
    wait_idle();

    // Zero rate.
    set_defaults();
    cfg_vals[CFG_RATE] = '0;
    apply_config();
    send_item('0, fx(5));
    send_item('0, fx(-5));
    wait_idle();

    // A write to an index past the register list must change nothing.
    set_defaults();
    apply_config();
    cfg_we    <= 1'b1;
    cfg_index <= CfgSpareIndex;
    cfg_data  <= '1;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_item(fx(2), '0);
    send_item('0, fx(3));
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_defaults();
        1: set_extremes_high();
        2: begin
          set_extremes_high();
          cfg_vals[CFG_GAIN] = WordMin;
          cfg_vals[CFG_POLE] = '0;
          cfg_vals[CFG_ZERO] = '0;
          cfg_vals[CFG_STEP] = DataW'(1);
        end
        default: randomize_config();
      endcase
      apply_config();
      if (p == 3) begin
        run_items(25);
        hold_reqs <= hold_reqs + 1;
        run_items(28);
      end else if (p == 5) begin
        run_items(25);
        wait_idle();
        run_items(28);
      end else begin
        run_items(53);
      end
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d items under %0d register settings; %0d commands checked.",
             items_sent, settings_applied, checked);
    $display("Covered error saturation, zero divisor, crossed clamps, zero rate and a long hold-off.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
